>>> hw/rtl/ilid_pkg.sv
// shared types and constants for the indexed list block
// no dependencies
package ilid_pkg;

	typedef logic signed [31:0] value_t;
	typedef logic [1:0]         cmd_t;
	typedef logic [3:0]         pos_t;

	localparam cmd_t CMD_FRONT  = 2'd0;
	localparam cmd_t CMD_BACK   = 2'd1;
	localparam cmd_t CMD_REMOVE = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} state_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_FRONT,
		CELL_BACK,
		CELL_REMOVE,
		CELL_ROTATE
	} cell_op_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		cell_op_t op;
		value_t   value;
	} cell_ctl_t;

	// dump status from the controller to the result channel
	typedef struct packed {
		logic valid;
		logic present;
		logic last;
		logic rejected;
	} dump_st_t;

endpackage

>>> hw/rtl/ilid_req_if.sv
// request channel: command, value and position with valid/ready
// depends on ilid_pkg
interface ilid_req_if;
	import ilid_pkg::*;

	logic   valid;
	logic   ready;
	cmd_t   command;
	value_t value;
	pos_t   position;

	modport source (output valid, output command, output value, output position, input ready);
	modport sink   (input valid, input command, input value, input position, output ready);
endinterface

>>> hw/rtl/ilid_rsp_if.sv
// result channel: one list entry per transfer with valid/ready
// depends on ilid_pkg
interface ilid_rsp_if;
	import ilid_pkg::*;

	logic   valid;
	logic   ready;
	value_t element;
	logic   present;
	logic   last;
	logic   rejected;

	modport source (output valid, output element, output present, output last,
		output rejected, input ready);
	modport sink   (input valid, input element, input present, input last,
		input rejected, output ready);
endinterface

>>> hw/rtl/ilid_cell.sv
// one list slot: holds an entry and takes a neighbor's entry on shifts
// depends on ilid_pkg
module ilid_cell #(
	parameter int INDEX = 0,
	parameter int CNT_W = 5
) (
	input  logic                clk,
	input  ilid_pkg::cell_ctl_t ctl,
	input  logic [CNT_W-1:0]    count,
	input  logic [CNT_W-1:0]    pos,
	input  ilid_pkg::value_t    left,
	input  ilid_pkg::value_t    right,
	input  ilid_pkg::value_t    first,
	output ilid_pkg::value_t    data
);
	import ilid_pkg::*;

	localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);
	localparam logic [CNT_W-1:0] MY_NXT = CNT_W'(INDEX + 1);

	value_t data_q;
	value_t data_d;

	always_comb begin
		data_d = data_q;
		case (ctl.op)
			CELL_FRONT: begin
				data_d = left;
			end
			CELL_BACK: begin
				if (MY_IDX == count) begin
					data_d = ctl.value;
				end
			end
			CELL_REMOVE: begin
				if (MY_IDX >= pos) begin
					data_d = right;
				end
			end
			CELL_ROTATE: begin
				// tail of the list wraps around to the head entry
				if (MY_NXT == count) begin
					data_d = first;
				end else if (MY_IDX < count) begin
					data_d = right;
				end
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;
endmodule

>>> hw/rtl/ilid_ctrl.sv
// request decode, fill count and dump sequencing for the cell chain
// depends on ilid_pkg
module ilid_ctrl #(
	parameter int CAPACITY = 16,
	parameter int CNT_W    = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  ilid_pkg::cmd_t      command,
	input  ilid_pkg::value_t    value,
	input  ilid_pkg::pos_t      position,
	input  logic                out_fire,
	output logic                in_ready,
	output ilid_pkg::cell_ctl_t ctl,
	output logic [CNT_W-1:0]    count,
	output logic [CNT_W-1:0]    pos,
	output ilid_pkg::dump_st_t  st
);
	import ilid_pkg::*;

	localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
	localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic             rej_q, rej_d;
	logic [CMP_W-1:0] pos_w;
	logic [CMP_W-1:0] count_w;
	logic             full;
	logic             last;

	assign pos_w   = CMP_W'(position);
	assign count_w = CMP_W'(count_q);
	assign full    = (count_q == CAP);
	assign last    = (count_q == '0) || ((idx_q + CNT_W'(1)) == count_q);

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		rej_d     = rej_q;
		ctl.op    = CELL_HOLD;
		ctl.value = value;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = ST_DUMP;
					idx_d   = '0;
					rej_d   = 1'b0;
					case (command)
						CMD_FRONT, CMD_BACK: begin
							if (full) begin
								rej_d = 1'b1;
							end else begin
								ctl.op  = (command == CMD_FRONT) ? CELL_FRONT : CELL_BACK;
								count_d = count_q + CNT_W'(1);
							end
						end
						CMD_REMOVE: begin
							if (pos_w >= count_w) begin
								rej_d = 1'b1;
							end else begin
								ctl.op  = CELL_REMOVE;
								count_d = count_q - CNT_W'(1);
							end
						end
						default: begin
							rej_d = 1'b1;
						end
					endcase
				end
			end
			ST_DUMP: begin
				if (out_fire) begin
					// rotating once per transfer leaves the order intact after the dump
					ctl.op = CELL_ROTATE;
					idx_d  = idx_q + CNT_W'(1);
					if (last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			rej_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			rej_q   <= rej_d;
		end
	end

	assign in_ready    = (state_q == ST_IDLE);
	assign count       = count_q;
	assign pos         = pos_w[CNT_W-1:0];
	assign st.valid    = (state_q == ST_DUMP);
	assign st.present  = (count_q != '0);
	assign st.last     = last;
	assign st.rejected = rej_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP)
		else $error("fill count above capacity");

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && st.valid))
		else $error("request taken while a dump is open");

	a_dump_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && last |=> in_ready)
		else $error("dump did not close after the final transfer");

	a_unused_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && command != CMD_FRONT && command != CMD_BACK && command != CMD_REMOVE
		|=> st.rejected && $stable(count_q))
		else $error("unused command changed the list");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!in_fire |=> $stable(count_q))
		else $error("fill count moved without a request");
endmodule

>>> hw/rtl/indexed_list_insert_delete.sv
// top level: controller plus a chain of list cells
// depends on ilid_pkg, ilid_req_if, ilid_rsp_if, ilid_cell, ilid_ctrl
//
//  channel  modport  carries                         per transfer
//  req      sink     command, value, position        one request
//  rsp      source   element, present, last, rejected one list entry
//
// a request is taken in a single handshake; its dump then gives max(count, 1) result
// transfers, one per cycle when rsp.ready is high, a pace set by the single result port
// reading cell 0 while the chain rotates. req.ready is low for the whole dump; a stall
// on rsp simply holds the chain. reset empties the list, entry contents are not cleared.
module indexed_list_insert_delete #(
	parameter int CAPACITY = 16
) (
	input logic       clk,
	input logic       arst_n,
	ilid_req_if.sink  req,
	ilid_rsp_if.source rsp
);
	import ilid_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	cell_ctl_t        ctl;
	dump_st_t         st;
	logic [CNT_W-1:0] count;
	logic [CNT_W-1:0] pos;
	logic             in_fire;
	logic             out_fire;
	value_t           data  [CAPACITY];
	value_t           left  [CAPACITY];
	value_t           right [CAPACITY];

	assign in_fire  = req.valid && req.ready;
	assign out_fire = rsp.valid && rsp.ready;

	ilid_ctrl #(
		.CAPACITY (CAPACITY),
		.CNT_W    (CNT_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.command  (req.command),
		.value    (req.value),
		.position (req.position),
		.out_fire (out_fire),
		.in_ready (req.ready),
		.ctl      (ctl),
		.count    (count),
		.pos      (pos),
		.st       (st)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign left[i] = ctl.value;
		end else begin : g_body
			assign left[i] = data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign right[i] = data[i];
		end else begin : g_inner
			assign right[i] = data[i+1];
		end

		ilid_cell #(
			.INDEX (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.count (count),
			.pos   (pos),
			.left  (left[i]),
			.right (right[i]),
			.first (data[0]),
			.data  (data[i])
		);
	end

	assign rsp.valid    = st.valid;
	assign rsp.element  = st.present ? data[0] : '0;
	assign rsp.present  = st.present;
	assign rsp.last     = st.last;
	assign rsp.rejected = st.rejected;
endmodule
